/* hdl/cixd_pkg.sv */
// ----------------------------------------------------------------------------
// cixd_pkg
// Shared constants and types for the chunk interleave XOR decoder.
// ----------------------------------------------------------------------------
package cixd_pkg;

   localparam int FS_W  = 24;   // file size / budget register width
   localparam int KEY_W = 8;
   localparam int OUT_W = 24;   // out_offset port width
   localparam int IDX_W = 3;    // csr index width

   localparam logic [IDX_W-1:0] CSR_FILE_SIZE   = 3'd0;
   localparam logic [IDX_W-1:0] CSR_BYTE_BUDGET = 3'd1;
   localparam logic [IDX_W-1:0] CSR_CHUNK_SIZE  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_KEY_START   = 3'd3;
   localparam logic [IDX_W-1:0] CSR_KEY_STEP    = 3'd4;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_FINISH
   } div_state_type;

   typedef struct packed {
      logic            busy;
      logic [FS_W-1:0] coded_len;
   } div_status_type;

   typedef struct packed {
      logic [FS_W-1:0]  byte_budget;
      logic [KEY_W-1:0] key_start;
      logic [KEY_W-1:0] key_step;
   } map_cfg_type;

   typedef struct packed {
      logic [OUT_W-1:0] offset;
      logic [KEY_W-1:0] value;
      logic             decoded;
   } result_type;

endpackage

/* hdl/chunk_interleave_xor_decrypt_top.sv */
// ----------------------------------------------------------------------------
// chunk_interleave_xor_decrypt_top
// An accepted request word appears as its response word in the next cycle.
// Throughput: one word per cycle while the divider is idle; the response register frees as it drains.
// A write to file_size or chunk_size starts a bit-serial remainder pass over
// the 24 dividend bits, then a finish step, with req_ready low.
// Reset (synchronous) clears the map counters and loads register reset values; the divider bit count is not reset.
// ----------------------------------------------------------------------------
module chunk_interleave_xor_decrypt_top #(
   parameter int OFFSET_WIDTH = 24,
   parameter int CHUNK_WIDTH  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel: file bytes in original order
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_in_byte,
   input  logic                           req_start_of_file,
   // response channel: destination offset and decoded byte
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [23:0]                    rsp_out_offset,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_was_decoded,
   // register write port
   input  logic                           csr_we,
   input  logic [cixd_pkg::IDX_W-1:0]     csr_index,
   input  logic [cixd_pkg::FS_W-1:0]      csr_wdata
);
   import cixd_pkg::*;

   // configuration registers
   logic [FS_W-1:0]        file_size_ff;
   logic [FS_W-1:0]        byte_budget_ff;
   logic [15:0]            chunk_size_ff;
   logic [KEY_W-1:0]       key_start_ff;
   logic [KEY_W-1:0]       key_step_ff;

   // response register
   logic                   rsp_valid_ff;
   result_type             rsp_ff;

   logic                   restart;
   logic                   accept;
   logic [CHUNK_WIDTH-1:0] chunk_low;
   logic [CHUNK_WIDTH-1:0] chunk_eff;
   div_status_type         div_status;
   map_cfg_type            map_cfg;
   result_type             result;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff   <= '0;
         byte_budget_ff <= '0;
         chunk_size_ff  <= 16'd1;
         key_start_ff   <= '0;
         key_step_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FILE_SIZE:   file_size_ff   <= csr_wdata;
            CSR_BYTE_BUDGET: byte_budget_ff <= csr_wdata;
            CSR_CHUNK_SIZE:  chunk_size_ff  <= csr_wdata[15:0];
            CSR_KEY_START:   key_start_ff   <= csr_wdata[KEY_W-1:0];
            CSR_KEY_STEP:    key_step_ff    <= csr_wdata[KEY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // chunk length of zero behaves as one
   assign chunk_low = chunk_size_ff[CHUNK_WIDTH-1:0];
   assign chunk_eff = (chunk_low == '0) ? CHUNK_WIDTH'(1) : chunk_low;

   // either operand of the remainder changing reruns the divider
   assign restart = csr_we && (csr_index == CSR_FILE_SIZE || csr_index == CSR_CHUNK_SIZE);

   cixd_remdiv #(
      .CHUNK_WIDTH(CHUNK_WIDTH)
   ) u_remdiv (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .file_size (file_size_ff),
      .chunk_eff (chunk_eff),
      .status    (div_status)
   );

   assign map_cfg.byte_budget = byte_budget_ff;
   assign map_cfg.key_start   = key_start_ff;
   assign map_cfg.key_step    = key_step_ff;

   // new word taken whenever the response slot is empty or draining,
   // held off only while the coded length is being recomputed
   assign req_ready = !div_status.busy && !restart && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   cixd_map #(
      .OFFSET_WIDTH(OFFSET_WIDTH),
      .CHUNK_WIDTH (CHUNK_WIDTH)
   ) u_map (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .sof       (req_start_of_file),
      .cfg       (map_cfg),
      .chunk_eff (chunk_eff),
      .coded_len (div_status.coded_len),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_offset  = rsp_ff.offset;
   assign rsp_out_byte    = rsp_ff.value;
   assign rsp_was_decoded = rsp_ff.decoded;

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !req_ready)
      else $error("request taken while coded length is stale");

   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no response");

endmodule

/* hdl/cixd_remdiv.sv */
// ----------------------------------------------------------------------------
// cixd_remdiv
// Bit-serial remainder of file size by chunk length, then coded length.
// ----------------------------------------------------------------------------
module cixd_remdiv #(
   parameter int CHUNK_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic [cixd_pkg::FS_W-1:0]     file_size,
   input  logic [CHUNK_WIDTH-1:0]        chunk_eff,
   output cixd_pkg::div_status_type      status
);
   import cixd_pkg::*;

   localparam int CNT_W = $clog2(FS_W);

   div_state_type          state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CHUNK_WIDTH-1:0] rem_ff, rem_in;
   logic [FS_W-1:0]        coded_ff, coded_in;

   logic [CHUNK_WIDTH:0]   trial;
   logic [CHUNK_WIDTH:0]   diff;
   logic [CHUNK_WIDTH-1:0] quarter;
   logic [FS_W-1:0]        skip;
   logic [FS_W-1:0]        coded_calc;

   assign trial      = {rem_ff, file_size[count_ff]};
   assign diff       = trial - {1'b0, chunk_eff};
   assign quarter    = chunk_eff >> 2;
   assign skip       = ((rem_ff < quarter) ? FS_W'(rem_ff) : '0) + FS_W'(file_size[0]);
   assign coded_calc = (skip >= file_size) ? '0 : file_size - skip;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         coded_ff <= '0;
      end else begin
         state_ff <= state_in;
         coded_ff <= coded_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      coded_in = coded_ff;
      unique case (state_ff)
         DIV_IDLE: begin
         end
         DIV_RUN: begin
            // one dividend bit per cycle, MSB first
            rem_in   = (trial >= {1'b0, chunk_eff}) ? diff[CHUNK_WIDTH-1:0]
                                                    : trial[CHUNK_WIDTH-1:0];
            count_in = count_ff - CNT_W'(1);
            if (count_ff == '0) begin
               state_in = DIV_FINISH;
            end
         end
         DIV_FINISH: begin
            coded_in = coded_calc;
            state_in = DIV_IDLE;
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
      if (restart) begin
         state_in = DIV_RUN;
         count_in = CNT_W'(FS_W - 1);
         rem_in   = '0;
      end
   end

   assign status.busy      = (state_ff != DIV_IDLE);
   assign status.coded_len = coded_ff;

   a_restart_busy: assert property (@(posedge clock) disable iff (reset)
      restart |=> state_ff == DIV_RUN)
      else $error("divider did not start after restart");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_FINISH && !restart) |=> state_ff == DIV_IDLE)
      else $error("divider did not return to idle after finish");

endmodule

/* hdl/cixd_map.sv */
// ----------------------------------------------------------------------------
// cixd_map
// Per-byte chunk tracking, destination offset and key stream.
// ----------------------------------------------------------------------------
module cixd_map #(
   parameter int OFFSET_WIDTH = 24,
   parameter int CHUNK_WIDTH  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [cixd_pkg::KEY_W-1:0]     in_byte,
   input  logic                           sof,
   input  cixd_pkg::map_cfg_type          cfg,
   input  logic [CHUNK_WIDTH-1:0]         chunk_eff,
   input  logic [cixd_pkg::FS_W-1:0]      coded_len,
   output cixd_pkg::result_type           result
);
   import cixd_pkg::*;

   logic [OFFSET_WIDTH-1:0] fp_ff, fp_in;
   logic [OFFSET_WIDTH-1:0] dest_ff, dest_in;
   logic [OFFSET_WIDTH-1:0] second_ff, second_in;
   logic [CHUNK_WIDTH-1:0]  left_ff, left_in;
   logic [CHUNK_WIDTH-1:0]  first_left_ff, first_left_in;
   logic [FS_W-1:0]         coded_ff, coded_in;
   logic [FS_W-1:0]         budget_ff, budget_in;
   logic [KEY_W-1:0]        key_ff, key_in;

   logic [OFFSET_WIDTH-1:0] fp_cur;
   logic [FS_W-1:0]         coded_cur;
   logic [FS_W-1:0]         budget_cur;
   logic [KEY_W-1:0]        key_cur;
   logic [CHUNK_WIDTH-1:0]  left_cur;
   logic [CHUNK_WIDTH-1:0]  first_left_cur;
   logic                    active;
   logic                    start;
   logic                    coded;
   logic [CHUNK_WIDTH-1:0]  new_len;
   logic [CHUNK_WIDTH:0]    half_wide;
   logic [CHUNK_WIDTH-1:0]  half;
   logic [OFFSET_WIDTH-1:0] first_off;
   logic [OFFSET_WIDTH-1:0] second_off;
   logic [OFFSET_WIDTH-1:0] third_off;
   logic [OFFSET_WIDTH-1:0] offset;
   logic [OFFSET_WIDTH+OUT_W-1:0] off_wide;

   // start of file restarts everything before the byte is looked at
   assign fp_cur         = sof ? '0 : fp_ff;
   assign coded_cur      = sof ? coded_len : coded_ff;
   assign budget_cur     = sof ? cfg.byte_budget : budget_ff;
   assign key_cur        = sof ? cfg.key_start : key_ff;
   assign left_cur       = sof ? '0 : left_ff;
   assign first_left_cur = sof ? '0 : first_left_ff;

   assign active  = (left_cur != '0);
   assign start   = !active && (coded_cur != '0) && (budget_cur != '0);
   assign coded   = start || active;
   assign new_len = (coded_cur < FS_W'(chunk_eff)) ? coded_cur[CHUNK_WIDTH-1:0] : chunk_eff;

   assign half_wide  = ({1'b0, new_len} + (CHUNK_WIDTH+1)'(1)) >> 1;
   assign half       = half_wide[CHUNK_WIDTH-1:0];
   assign first_off  = fp_cur + OFFSET_WIDTH'(new_len) - OFFSET_WIDTH'(1);
   assign second_off = fp_cur + OFFSET_WIDTH'(new_len) - OFFSET_WIDTH'(2);
   assign third_off  = fp_cur + OFFSET_WIDTH'(new_len) - OFFSET_WIDTH'(3);

   always_comb begin
      fp_in         = fp_cur + OFFSET_WIDTH'(1);
      dest_in       = dest_ff;
      second_in     = second_ff;
      left_in       = left_cur;
      first_left_in = first_left_cur;
      coded_in      = coded_cur;
      budget_in     = budget_cur;
      key_in        = coded ? key_cur + cfg.key_step : key_cur;
      offset        = fp_cur;
      if (start) begin
         offset        = first_off;
         second_in     = second_off;
         dest_in       = (half == CHUNK_WIDTH'(1)) ? second_off : third_off;
         left_in       = new_len - CHUNK_WIDTH'(1);
         first_left_in = half - CHUNK_WIDTH'(1);
         coded_in      = coded_cur - FS_W'(new_len);
         budget_in     = (budget_cur > FS_W'(new_len)) ? budget_cur - FS_W'(new_len) : '0;
      end else if (active) begin
         offset  = dest_ff;
         left_in = left_cur - CHUNK_WIDTH'(1);
         // odd positions run downward first, then even ones from base+c-2
         if (first_left_cur == CHUNK_WIDTH'(1)) begin
            dest_in = second_ff;
         end else begin
            dest_in = dest_ff - OFFSET_WIDTH'(2);
         end
         if (first_left_cur != '0) begin
            first_left_in = first_left_cur - CHUNK_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fp_ff         <= '0;
         left_ff       <= '0;
         first_left_ff <= '0;
         coded_ff      <= '0;
         budget_ff     <= '0;
         key_ff        <= '0;
      end else if (accept) begin
         fp_ff         <= fp_in;
         left_ff       <= left_in;
         first_left_ff <= first_left_in;
         coded_ff      <= coded_in;
         budget_ff     <= budget_in;
         key_ff        <= key_in;
      end
      if (accept) begin
         dest_ff   <= dest_in;
         second_ff <= second_in;
      end
   end

   assign off_wide       = {{OUT_W{1'b0}}, offset};
   assign result.offset  = off_wide[OUT_W-1:0];
   assign result.value   = coded ? (in_byte ^ key_cur) : in_byte;
   assign result.decoded = coded;

   a_phase_order: assert property (@(posedge clock) disable iff (reset)
      first_left_ff <= left_ff)
      else $error("first-phase count exceeds chunk bytes left");

   a_key_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && !sof && !coded) |=> key_ff == $past(key_ff))
      else $error("key moved on a passed-through byte");

endmodule
